// ===== src/hcr_pkg.sv =====
`default_nettype none

package hcr_pkg;

	localparam int HEIGHT_W = 16;
	localparam int SPAN_W   = 32;
	localparam int PROD_W   = HEIGHT_W + SPAN_W;
	localparam int COEFF_W  = 17;
	localparam int FRAC_W   = 14;
	localparam int CHAN_W   = 8;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h10000;
	localparam logic [1:0] SCHEME_WHITE = 2'd0;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [1:0] {
		REG_HEIGHT_MIN   = 2'd0,
		REG_INV_SPAN     = 2'd1,
		REG_COLOR_SCHEME = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height_min;
		logic [SPAN_W-1:0]          inv_span;
		logic [1:0]                 color_scheme;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	// Nine control colors for each of the three built-in ramps.
	localparam rgb_t RAMP_TABLE [0:2][0:8] = '{
		'{
			'{8'd47,  8'd86,  8'd106}, '{8'd38,  8'd110, 8'd143}, '{8'd52,  8'd133, 8'd138},
			'{8'd49,  8'd100, 8'd75},  '{8'd57,  8'd120, 8'd40},  '{8'd47,  8'd114, 8'd71},
			'{8'd156, 8'd146, 8'd92},  '{8'd163, 8'd156, 8'd124}, '{8'd151, 8'd151, 8'd140}
		},
		'{
			'{8'd113, 8'd83,  8'd28},  '{8'd152, 8'd117, 8'd20},  '{8'd28,  8'd93,  8'd10},
			'{8'd70,  8'd145, 8'd53},  '{8'd100, 8'd143, 8'd66},  '{8'd127, 8'd140, 8'd97},
			'{8'd128, 8'd140, 8'd100}, '{8'd201, 8'd202, 8'd201}, '{8'd248, 8'd247, 8'd248}
		},
		'{
			'{8'd45,  8'd80,  8'd0},   '{8'd69,  8'd44,  8'd0},   '{8'd93,  8'd28,  8'd0},
			'{8'd122, 8'd45,  8'd0},   '{8'd156, 8'd63,  8'd7},   '{8'd169, 8'd111, 8'd25},
			'{8'd190, 8'd172, 8'd49},  '{8'd225, 8'd201, 8'd105}, '{8'd225, 8'd208, 8'd176}
		}
	};

	// Linear blend of two control values, floored: lo + floor((hi - lo) * frac / 8192).
	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] lo,
		input logic [CHAN_W-1:0] hi, input logic [FRAC_W-1:0] frac);
		logic signed [CHAN_W:0]          delta;
		logic signed [CHAN_W+FRAC_W:0]   prod;
		logic signed [CHAN_W+1:0]        sum;
		delta = $signed({1'b0, hi}) - $signed({1'b0, lo});
		prod  = delta * $signed({1'b0, frac});
		sum   = $signed({2'b00, lo}) + (CHAN_W + 2)'(prod >>> (FRAC_W - 1));
		return sum[CHAN_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/height_color_ramp_top.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid, in_stall   height (16 bit signed)
// output    out        out_valid, out_stall red, green, blue (8 bit unsigned each)
// config    in         APB psel/penable     height_min, inv_span, color_scheme
//
// An accepted sample passes through three registers, the input, product and
// result registers, before it leaves; a new sample is taken every cycle while
// the result side keeps up.
// Reset clears the valid bits and loads the register defaults; there is no clearing pass.
// A stall on the output freezes the whole pipeline, so in_stall follows out_stall
// only while a result is waiting.

module height_color_ramp_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [hcr_pkg::HEIGHT_W-1:0] height,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic             [hcr_pkg::CHAN_W-1:0]  red,
	output logic             [hcr_pkg::CHAN_W-1:0]  green,
	output logic             [hcr_pkg::CHAN_W-1:0]  blue,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [hcr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic        [hcr_pkg::DATA_W-1:0]  pwdata,
	output logic             [hcr_pkg::DATA_W-1:0]  prdata,
	output logic                                    pready
);

	hcr_pkg::cfg_t              cfg;
	logic [hcr_pkg::PROD_W-1:0] prod_s2;
	hcr_pkg::rgb_t              color_s3;
	logic                       advance;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;

	// The pipeline moves as one unit whenever the result register can be
	// emptied or holds nothing, so bubbles are squeezed out only at the output.
	assign advance   = !(valid_s3 && out_stall);
	assign in_stall  = !advance;
	assign out_valid = valid_s3;
	assign red       = color_s3.r;
	assign green     = color_s3.g;
	assign blue      = color_s3.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	hcr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Normalization: subtract the floor height and scale by the reciprocal span.
	hcr_scale u_scale (
		.clk     (clk),
		.advance (advance),
		.height  (height),
		.cfg     (cfg),
		.prod_s2 (prod_s2)
	);

	// Clamp, pick the segment and blend the two control colors.
	hcr_ramp u_ramp (
		.clk      (clk),
		.advance  (advance),
		.prod_s2  (prod_s2),
		.cfg      (cfg),
		.color_s3 (color_s3)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted sample did not enter the pipeline");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("sample lost between input and product stage");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && advance |=> out_valid)
		else $error("sample lost between product stage and result");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && advance && cfg.color_scheme == hcr_pkg::SCHEME_WHITE
		|=> red == hcr_pkg::CHAN_MAX && green == hcr_pkg::CHAN_MAX &&
			blue == hcr_pkg::CHAN_MAX)
		else $error("white scheme produced a non-white result");

endmodule

`default_nettype wire

// ===== src/hcr_cfg_regs.sv =====
`default_nettype none

module hcr_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [hcr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [hcr_pkg::DATA_W-1:0] pwdata,
	output logic      [hcr_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output hcr_pkg::cfg_t                   cfg
);

	hcr_pkg::cfg_t    cfg_q;
	hcr_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = hcr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_min   <= '0;
			cfg_q.inv_span     <= 32'd65536;
			cfg_q.color_scheme <= 2'd1;
		end else if (wr_en) begin
			unique case (idx)
				hcr_pkg::REG_HEIGHT_MIN:   cfg_q.height_min   <= pwdata[15:0];
				hcr_pkg::REG_INV_SPAN:     cfg_q.inv_span     <= pwdata;
				hcr_pkg::REG_COLOR_SCHEME: cfg_q.color_scheme <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			hcr_pkg::REG_HEIGHT_MIN:   prdata = {16'd0, cfg_q.height_min};
			hcr_pkg::REG_INV_SPAN:     prdata = cfg_q.inv_span;
			hcr_pkg::REG_COLOR_SCHEME: prdata = {30'd0, cfg_q.color_scheme};
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/hcr_scale.sv =====
`default_nettype none

module hcr_scale (
	input  wire logic                              clk,
	input  wire logic                              advance,
	input  wire logic signed [hcr_pkg::HEIGHT_W-1:0] height,
	input  wire hcr_pkg::cfg_t                     cfg,
	output logic             [hcr_pkg::PROD_W-1:0] prod_s2
);

	logic signed [hcr_pkg::HEIGHT_W-1:0] height_s1;
	logic signed [hcr_pkg::HEIGHT_W:0]   diff;
	logic        [hcr_pkg::PROD_W-1:0]   prod;

	// The difference is exact in 17 bits; a positive one fits in 16.
	always_comb begin
		diff = $signed({height_s1[15], height_s1}) -
			$signed({cfg.height_min[15], cfg.height_min});
		if (diff[hcr_pkg::HEIGHT_W] || diff == '0) begin
			prod = '0;
		end else begin
			prod = diff[hcr_pkg::HEIGHT_W-1:0] * cfg.inv_span;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			height_s1 <= height;
			prod_s2   <= prod;
		end
	end

endmodule

`default_nettype wire

// ===== src/hcr_ramp.sv =====
`default_nettype none

module hcr_ramp (
	input  wire logic                        clk,
	input  wire logic                        advance,
	input  wire logic [hcr_pkg::PROD_W-1:0]  prod_s2,
	input  wire hcr_pkg::cfg_t               cfg,
	output hcr_pkg::rgb_t                    color_s3
);

	logic [hcr_pkg::COEFF_W-1:0] coeff;
	logic [2:0]                  seg;
	logic [hcr_pkg::FRAC_W-1:0]  frac;
	logic [1:0]                  tab;
	logic [3:0]                  lo_idx;
	logic [3:0]                  hi_idx;
	hcr_pkg::rgb_t               lo_c;
	hcr_pkg::rgb_t               hi_c;
	hcr_pkg::rgb_t               color;

	always_comb begin
		// Anything at or past 1.0 saturates to the top of the ramp.
		if (prod_s2[hcr_pkg::PROD_W-1:16] > 32'(hcr_pkg::COEFF_ONE)) begin
			coeff = hcr_pkg::COEFF_ONE;
		end else begin
			coeff = prod_s2[32:16];
		end
		if (coeff[16]) begin
			seg  = 3'd7;
			frac = 14'd8192;
		end else begin
			seg  = coeff[15:13];
			frac = {1'b0, coeff[12:0]};
		end
		tab    = cfg.color_scheme - 2'd1;
		lo_idx = {1'b0, seg};
		hi_idx = lo_idx + 4'd1;
		lo_c   = hcr_pkg::RAMP_TABLE[tab][lo_idx];
		hi_c   = hcr_pkg::RAMP_TABLE[tab][hi_idx];
		if (cfg.color_scheme == hcr_pkg::SCHEME_WHITE) begin
			color = '{hcr_pkg::CHAN_MAX, hcr_pkg::CHAN_MAX, hcr_pkg::CHAN_MAX};
		end else begin
			color.r = hcr_pkg::blend(lo_c.r, hi_c.r, frac);
			color.g = hcr_pkg::blend(lo_c.g, hi_c.g, frac);
			color.b = hcr_pkg::blend(lo_c.b, hi_c.b, frac);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_s3 <= color;
		end
	end

endmodule

`default_nettype wire
